/* rtl/crpw_pkg.sv */
// Package for the Catmull-Rom path walker: field widths, codes and types.
// Shared by crpw_ptab, crpw_mac and catmull_rom_path_walker_core; no dependencies.
`timescale 1ns / 1ps
package crpw_pkg;

  localparam int COORD_W    = 13;  // control point coordinate, signed
  localparam int POS_W      = 29;  // 17.12 output position, signed
  localparam int PHASE_W    = 13;  // phase within a segment, 0..4096
  localparam int COEF_W     = 18;  // polynomial coefficient, signed
  localparam int TOP_W      = 14;  // powers of t, signed view of 0..4096
  localparam int ACC_W      = 32;  // product and accumulator width
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int COUNT_W    = 7;   // point_count register field
  localparam int PHASE_ONE  = 4096;

  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_COEF,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic mul;   // capture a new product
    logic init;  // load the accumulator with the base term
    logic add;   // add the held product into the accumulator
  } mac_ctl_t;

endpackage

/* rtl/crpw_ptab.sv */
// Control point table: x and y stores with one write and one registered read port.
// Depends on crpw_pkg.
`timescale 1ns / 1ps
module crpw_ptab #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [AW-1:0]                       waddr,
  input  logic signed [crpw_pkg::COORD_W-1:0] wx,
  input  logic signed [crpw_pkg::COORD_W-1:0] wy,
  input  logic [AW-1:0]                       raddr,
  output logic signed [crpw_pkg::COORD_W-1:0] rx,
  output logic signed [crpw_pkg::COORD_W-1:0] ry
);
  import crpw_pkg::*;

  logic signed [COORD_W-1:0] mem_x [DEPTH];
  logic signed [COORD_W-1:0] mem_y [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
    end
  end

  always_ff @(posedge clk) begin
    rx <= mem_x[raddr];
    ry <= mem_y[raddr];
  end

endmodule

/* rtl/crpw_mac.sv */
// Shared multiply-accumulate unit: one registered signed multiplier and an accumulator.
// Depends on crpw_pkg.
`timescale 1ns / 1ps
module crpw_mac (
  input  logic                               clk,
  input  crpw_pkg::mac_ctl_t                 ctl,
  input  logic signed [crpw_pkg::COEF_W-1:0] a_op,
  input  logic signed [crpw_pkg::TOP_W-1:0]  b_op,
  input  logic signed [crpw_pkg::ACC_W-1:0]  base,
  output logic signed [crpw_pkg::ACC_W-1:0]  prod,
  output logic signed [crpw_pkg::ACC_W-1:0]  acc
);
  import crpw_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      // widen both operands first so the product forms at full width
      prod <= ACC_W'(a_op) * ACC_W'(b_op);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      acc <= base;
    end else if (ctl.add) begin
      acc <= acc + prod;
    end
  end

endmodule

/* rtl/catmull_rom_path_walker_core.sv */
// Top level of the Catmull-Rom path walker: sequencer, index and phase logic.
// Depends on crpw_pkg, crpw_ptab and crpw_mac.
`timescale 1ns / 1ps
// Usage
//   Command channel: an item is taken at a rising edge with start high and busy low.
//   func selects write point, tick or restart. Write and restart complete in the
//   accepting cycle and never raise busy; a tick raises busy until its result is out.
//   Configuration channel: cfg_valid/cfg_ready with cfg_index (0 speed, 1 point
//   count) and cfg_data; cfg_ready is always high. Write it only while idle.
//   Result channel: result_valid strobes for exactly one cycle with pos_x, pos_y
//   and wrapped. The receiver cannot stall it; a result not taken is lost.
// Sequence
//   A tick keeps busy high through the bit-serial segment modulo (ST_MOD), four
//   table reads through the registered read port (ST_READ), the coefficient
//   step (ST_COEF), eight products through the single shared multiplier, each a
//   multiply state and an accumulate state, and ST_OUT. Its strobe comes in the
//   cycle in which busy falls, when the next item may already be taken.
// Reset
//   rst clears phase, segment and speed, sets point count to one and returns the
//   sequencer to idle. The point table is not cleared; write points before use.
module catmull_rom_path_walker_core #(
  parameter int MAX_POINTS = 64
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [1:0]                              func,
  input  logic [5:0]                              point_index,
  input  logic signed [crpw_pkg::COORD_W-1:0]     point_x,
  input  logic signed [crpw_pkg::COORD_W-1:0]     point_y,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [crpw_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [crpw_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic                                    result_valid,
  output logic signed [crpw_pkg::POS_W-1:0]       pos_x,
  output logic signed [crpw_pkg::POS_W-1:0]       pos_y,
  output logic                                    wrapped
);
  import crpw_pkg::*;

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CW   = ($clog2(MAX_POINTS + 1) > COUNT_W) ? $clog2(MAX_POINTS + 1) : COUNT_W;
  localparam int BC_W = $clog2(AW);
  // sequencer steps of the multiply pass
  localparam logic [2:0] STEP_T2   = 3'd0;
  localparam logic [2:0] STEP_T3   = 3'd1;
  localparam logic [2:0] STEP_AX   = 3'd2;
  localparam logic [2:0] STEP_BX   = 3'd3;
  localparam logic [2:0] STEP_CX   = 3'd4;
  localparam logic [2:0] STEP_AY   = 3'd5;
  localparam logic [2:0] STEP_BY   = 3'd6;
  localparam logic [2:0] STEP_CY   = 3'd7;
  localparam logic [2:0] READ_LAST = 3'd4;

  state_t state, state_next;

  logic [PHASE_W-1:0] speed;
  logic [CW-1:0]      count;
  logic [PHASE_W-1:0] phase;
  logic [AW-1:0]      segment;
  logic [BC_W-1:0]    bit_cnt;
  logic [2:0]         step;
  logic [CW-1:0]      rem;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      seg_adv;

  logic signed [COORD_W-1:0] px [4];
  logic signed [COORD_W-1:0] py [4];
  logic signed [COEF_W-1:0]  ax, bx, cx, ay, by, cy;
  logic [PHASE_W-1:0]        t2, t3;
  logic [COEF_W-1:0]         fx;

  logic accept;
  logic we;
  logic signed [COORD_W-1:0] rx, ry;

  // the command channel takes an item whenever the sequencer is idle
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign we        = accept && (func == FUNC_WRITE) && (32'(point_index) < 32'(MAX_POINTS));

  // ---------------------------------------------------------------------------
  // Configuration registers: clamp on write
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] cfg_count;
  assign cfg_count = cfg_data[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= '0;
      count <= CW'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SPEED: begin
          speed <= (cfg_data > PHASE_W'(PHASE_ONE)) ? PHASE_W'(PHASE_ONE) : cfg_data;
        end
        REG_COUNT: begin
          if (cfg_count == '0) begin
            count <= CW'(1);
          end else if (32'(cfg_count) > 32'(MAX_POINTS)) begin
            count <= CW'(MAX_POINTS);
          end else begin
            count <= CW'(cfg_count);
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Point table
  // ---------------------------------------------------------------------------
  crpw_ptab #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_ptab (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(point_index)),
    .wx    (point_x),
    .wy    (point_y),
    .raddr (idx),
    .rx    (rx),
    .ry    (ry)
  );

  // ---------------------------------------------------------------------------
  // Segment modulo: one restoring remainder bit per cycle, MSB first
  // ---------------------------------------------------------------------------
  logic [CW:0]   rem_shift;
  logic [CW:0]   rem_sub;
  logic [CW-1:0] rem_next;

  always_comb begin
    rem_shift = {rem, segment[bit_cnt]};
    rem_sub   = rem_shift - {1'b0, count};
    rem_next  = (rem_shift >= {1'b0, count}) ? rem_sub[CW-1:0] : rem_shift[CW-1:0];
  end

  // next table index, wrapping at the point count
  logic [AW:0]   idx_inc;
  logic [AW-1:0] idx_wrap;

  always_comb begin
    idx_inc  = {1'b0, idx} + (AW + 1)'(1);
    idx_wrap = (CW'(idx_inc) == count) ? '0 : idx_inc[AW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Coefficients of the cubic, from the four points of each axis
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0] ex [4];
  logic signed [COEF_W-1:0] ey [4];
  logic signed [COEF_W-1:0] ax_c, bx_c, cx_c, ay_c, by_c, cy_c;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ex[k] = COEF_W'(px[k]);
      ey[k] = COEF_W'(py[k]);
    end
    ax_c = ex[2] - ex[0];
    bx_c = (ex[0] <<< 1) - ((ex[1] <<< 2) + ex[1]) + (ex[2] <<< 2) - ex[3];
    cx_c = ex[3] - ((ex[2] <<< 1) + ex[2]) + ((ex[1] <<< 1) + ex[1]) - ex[0];
    ay_c = ey[2] - ey[0];
    by_c = (ey[0] <<< 1) - ((ey[1] <<< 2) + ey[1]) + (ey[2] <<< 2) - ey[3];
    cy_c = ey[3] - ((ey[2] <<< 1) + ey[2]) + ((ey[1] <<< 1) + ey[1]) - ey[0];
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: operand selection per step
  // ---------------------------------------------------------------------------
  mac_ctl_t                mac_ctl;
  logic signed [COEF_W-1:0] a_op;
  logic signed [TOP_W-1:0]  b_op;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  base_x, base_y;
  logic signed [TOP_W-1:0]  t_s, t2_s, t3_s;

  localparam int BASE_PAD = ACC_W - COORD_W - 13;

  always_comb begin
    t_s    = signed'({1'b0, phase});
    t2_s   = signed'({1'b0, t2});
    t3_s   = signed'({1'b0, t3});
    // 8192 * p1
    base_x = {{BASE_PAD{px[1][COORD_W-1]}}, px[1], 13'b0};
    base_y = {{BASE_PAD{py[1][COORD_W-1]}}, py[1], 13'b0};
    a_op   = '0;
    b_op   = t_s;
    unique case (step)
      STEP_T2: begin a_op = COEF_W'(t_s);  b_op = t_s;  end
      STEP_T3: begin a_op = COEF_W'(t2_s); b_op = t_s;  end
      STEP_AX: begin a_op = ax;            b_op = t_s;  end
      STEP_BX: begin a_op = bx;            b_op = t2_s; end
      STEP_CX: begin a_op = cx;            b_op = t3_s; end
      STEP_AY: begin a_op = ay;            b_op = t_s;  end
      STEP_BY: begin a_op = by;            b_op = t2_s; end
      STEP_CY: begin a_op = cy;            b_op = t3_s; end
      default: ;
    endcase
    base         = (step == STEP_AY) ? base_y : base_x;
    mac_ctl.mul  = (state == ST_MUL);
    // start each axis sum with its base term while the first product forms
    mac_ctl.init = (state == ST_MUL) && ((step == STEP_AX) || (step == STEP_AY));
    mac_ctl.add  = (state == ST_ACC) && (step != STEP_T2) && (step != STEP_T3);
  end

  crpw_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .a_op (a_op),
    .b_op (b_op),
    .base (base),
    .prod (prod),
    .acc  (acc)
  );

  // ---------------------------------------------------------------------------
  // Phase advance
  // ---------------------------------------------------------------------------
  logic [PHASE_W:0]   phase_sum;
  logic               wrap_now;
  logic [PHASE_W-1:0] phase_adv;

  always_comb begin
    phase_sum = {1'b0, phase} + {1'b0, speed};
    wrap_now  = phase_sum > (PHASE_W + 1)'(PHASE_ONE);
    phase_adv = wrap_now ? PHASE_W'(phase_sum - (PHASE_W + 1)'(PHASE_ONE))
                         : phase_sum[PHASE_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (func == FUNC_TICK)) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (bit_cnt == '0) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (step == READ_LAST) begin
          state_next = ST_COEF;
        end
      end
      ST_COEF: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC: begin
        state_next = (step == STEP_CY) ? ST_OUT : ST_MUL;
      end
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // phase and segment: restart clears, a finished tick advances
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= '0;
      segment <= '0;
    end else if (accept && (func == FUNC_RESTART)) begin
      phase   <= '0;
      segment <= '0;
    end else if (state == ST_OUT) begin
      phase <= phase_adv;
      if (wrap_now) begin
        segment <= seg_adv;
      end
    end
  end

  // result strobe lasts one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_OUT);
    end
  end

  // working registers of a tick
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        rem     <= '0;
        bit_cnt <= BC_W'(AW - 1);
      end
      ST_MOD: begin
        rem     <= rem_next;
        bit_cnt <= bit_cnt - BC_W'(1);
        if (bit_cnt == '0) begin
          idx  <= AW'(rem_next);
          step <= '0;
        end
      end
      ST_READ: begin
        // issue address of point k while capturing point k-1
        if (step != READ_LAST) begin
          idx <= idx_wrap;
        end
        if (step == 3'd1) begin
          seg_adv <= idx;
        end
        if (step != 3'd0) begin
          px[2'(step - 3'd1)] <= rx;
          py[2'(step - 3'd1)] <= ry;
        end
        step <= step + 3'd1;
      end
      ST_COEF: begin
        ax   <= ax_c;
        bx   <= bx_c;
        cx   <= cx_c;
        ay   <= ay_c;
        by   <= by_c;
        cy   <= cy_c;
        step <= STEP_T2;
      end
      ST_MUL: begin
        // x sum is complete once the y pass starts
        if (step == STEP_AY) begin
          fx <= acc[29:12];
        end
      end
      ST_ACC: begin
        if (step == STEP_T2) begin
          t2 <= prod[24:12];
        end
        if (step == STEP_T3) begin
          t3 <= prod[24:12];
        end
        step <= step + 3'd1;
      end
      ST_OUT: begin
        // 2048 * floor(f / 4096), kept to 29 bits
        pos_x   <= {fx, 11'b0};
        pos_y   <= {acc[29:12], 11'b0};
        wrapped <= wrap_now;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_strobe_from_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_OUT))
    else $error("result strobe without a finished tick");

  a_tick_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_TICK)) |=> busy)
    else $error("accepted tick did not start the sequencer");

  a_phase_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |=> (phase <= PHASE_W'(PHASE_ONE)))
    else $error("phase above one segment after advance");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

endmodule
